// ===== design/zero_crossing_gain_switch_top_assert.svh =====
// Assertion macros used by the top-level design file.
// Each use names its label, clock, reset, property and message.
`ifndef ZERO_CROSSING_GAIN_SWITCH_TOP_ASSERT_SVH
`define ZERO_CROSSING_GAIN_SWITCH_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ZCG_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ZCG_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ZCG_ASSERT(label, clk, rst, prop, msg)
`define ZCG_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== design/zcgs_pkg.sv =====
`timescale 1ns / 1ps

package zcgs_pkg;

  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 18;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
  localparam int MAX_CH   = 2 ** CH_W;

  typedef logic [CH_W-1:0]            chan_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [GAIN_W-1:0]          gain_t;

  localparam gain_t   UNITY_GAIN = 18'd65536;
  localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN = 24'sh800000;

  // Sign recorded for a pending gain change; zero samples record as negative.
  typedef enum logic [1:0] {
    SIGN_UNSET = 2'd0,
    SIGN_POS   = 2'd1,
    SIGN_NEG   = 2'd2
  } sign_t;

endpackage

// ===== design/zcgs_if.sv =====
`timescale 1ns / 1ps

interface zcgs_in_if;
  import zcgs_pkg::*;

  logic    valid;
  logic    ready;
  chan_t   channel;
  sample_t sample_in;
  gain_t   target_gain;

  modport source (output valid, output channel, output sample_in, output target_gain,
                  input ready);
  modport sink (input valid, input channel, input sample_in, input target_gain,
                output ready);
endinterface

interface zcgs_out_if;
  import zcgs_pkg::*;

  logic    valid;
  logic    ready;
  chan_t   channel_out;
  sample_t sample_out;
  logic    gain_switched;

  modport source (output valid, output channel_out, output sample_out, output gain_switched,
                  input ready);
  modport sink (input valid, input channel_out, input sample_out, input gain_switched,
                output ready);
endinterface

// ===== design/zero_crossing_gain_switch_top.sv =====
`timescale 1ns / 1ps
`include "zero_crossing_gain_switch_top_assert.svh"

// Per-channel gain stage that changes gain only at a zero crossing.
// Requests arrive on din (channel, signed 24-bit sample, target gain in Q2.16)
// and leave on dout (channel, scaled sample, gain_switched flag), one result
// per request, in order. Both channels use valid/ready; a request moves when
// both are high at a rising clock edge.
// The pipeline has three register stages: input register, product register
// (state lookup, switch decision and the 24x19 multiply), and output register
// (round toward zero and saturate). An accepted request passes through the
// input, product and output registers in order before it shows on dout. One
// request is taken every cycle while dout is ready. The per-channel gain and
// sign table is updated as a request leaves the input register, so requests
// back-to-back on one channel see each other's updates without stalls.
// Synchronous reset sets every channel to unity gain with no pending sign
// and empties the pipeline. When dout stalls, each stage holds its request
// and din.ready falls only once all three stages are full.
// Channels at or beyond CHANNELS change no state and return a zero sample.
module zero_crossing_gain_switch_top #(
  parameter int CHANNELS = 8
) (
  input logic        clk,
  input logic        rst,
  zcgs_in_if.sink    din,
  zcgs_out_if.source dout
);
  import zcgs_pkg::*;

  localparam int NUM   = (CHANNELS < MAX_CH) ? CHANNELS : MAX_CH;
  localparam int IDX_W = (NUM > 1) ? $clog2(NUM) : 1;
  localparam int DEPTH = 2 ** IDX_W;

  localparam logic signed [PROD_W-1:0] SAT_HI   = PROD_W'(SAMPLE_MAX);
  localparam logic signed [PROD_W-1:0] SAT_LO   = PROD_W'(SAMPLE_MIN);
  localparam logic signed [PROD_W-1:0] ROUND_UP = PROD_W'((2 ** FRAC_W) - 1);

  // Per-channel state
  gain_t gain_now [DEPTH];
  sign_t track    [DEPTH];

  // Pipeline occupancy
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  logic adv1;

  // Stage 1: input register
  chan_t   r1_ch;
  sample_t r1_sample;
  gain_t   r1_target;

  // Stage 2: product register
  chan_t                     r2_ch;
  logic signed [PROD_W-1:0]  r2_prod;
  logic                      r2_sw;

  // Stage 3: output register
  chan_t   r3_ch;
  sample_t r3_sample;
  logic    r3_sw;

  // Stage 1 logic
  logic               chan_ok;
  logic [IDX_W-1:0]   idx;
  gain_t              cur_gain;
  sign_t              cur_track;
  sign_t              sgn;
  sign_t              eff_track;
  logic               pending;
  logic               do_switch;
  sign_t              track_next;
  gain_t              gain_use;
  logic signed [PROD_W-1:0] prod_next;

  // Stage 2 logic
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [PROD_W-1:0] quot;
  sample_t                  sample_next;

  assign rdy3 = !v3 || dout.ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign adv1 = v1 && rdy2;

  assign din.ready = rdy1;

  assign chan_ok   = int'(r1_ch) < NUM;
  assign idx       = r1_ch[IDX_W-1:0];
  assign cur_gain  = gain_now[idx];
  assign cur_track = track[idx];

  always_comb begin
    sgn       = (r1_sample > 0) ? SIGN_POS : SIGN_NEG;
    eff_track = (cur_track == SIGN_UNSET) ? sgn : cur_track;
    pending   = chan_ok && (r1_target != cur_gain);
    // The first sample of a change compares with itself, so only zero switches it.
    do_switch = pending && ((sgn != eff_track) || (r1_sample == '0));

    if (!pending) begin
      track_next = cur_track;
    end else if (do_switch) begin
      track_next = SIGN_UNSET;
    end else begin
      track_next = eff_track;
    end

    if (!chan_ok) begin
      gain_use = '0;
    end else if (do_switch) begin
      gain_use = r1_target;
    end else begin
      gain_use = cur_gain;
    end
  end

  assign prod_next = PROD_W'(r1_sample) * PROD_W'($signed({1'b0, gain_use}));

  // Negative products are biased so the arithmetic shift rounds toward zero.
  assign prod_adj = r2_prod[PROD_W-1] ? (r2_prod + ROUND_UP) : r2_prod;
  assign quot     = prod_adj >>> FRAC_W;

  always_comb begin
    if (quot > SAT_HI) begin
      sample_next = SAMPLE_MAX;
    end else if (quot < SAT_LO) begin
      sample_next = SAMPLE_MIN;
    end else begin
      sample_next = quot[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        gain_now[i] <= UNITY_GAIN;
        track[i]    <= SIGN_UNSET;
      end
    end else begin
      if (rdy1) begin
        v1 <= din.valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (adv1 && chan_ok) begin
        track[idx] <= track_next;
        if (do_switch) begin
          gain_now[idx] <= r1_target;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && din.valid) begin
      r1_ch     <= din.channel;
      r1_sample <= din.sample_in;
      r1_target <= din.target_gain;
    end
    if (rdy2) begin
      r2_ch   <= r1_ch;
      r2_prod <= prod_next;
      r2_sw   <= do_switch;
    end
    if (rdy3) begin
      r3_ch     <= r2_ch;
      r3_sample <= sample_next;
      r3_sw     <= r2_sw;
    end
  end

  assign dout.valid         = v3;
  assign dout.channel_out   = r3_ch;
  assign dout.sample_out    = r3_sample;
  assign dout.gain_switched = r3_sw;

  `ZCG_ASSERT(a_switch_clears_sign, clk, rst, (adv1 && do_switch) |=> (track[$past(idx)] == SIGN_UNSET), "recorded sign not cleared after a gain switch")
  `ZCG_ASSERT(a_switch_takes_target, clk, rst, (adv1 && do_switch) |=> (gain_now[$past(idx)] == $past(r1_target)), "gain in use is not the target after a switch")
  `ZCG_ASSERT(a_bad_channel_silent, clk, rst, (adv1 && !chan_ok) |=> ((r2_prod == '0) && !r2_sw), "out-of-range channel produced a sample or a switch")
  `ZCG_ASSERT(a_stage2_holds, clk, rst, (v2 && !rdy3) |=> v2, "product stage dropped a request during a stall")

endmodule
